FILE: design/oat_pkg.sv
// Package for the outstanding acknowledgement table: codes, types and slot record.
package oat_pkg;

    typedef enum logic [2:0] {
        FUNC_MARK   = 3'd0,
        FUNC_CLEAR  = 3'd1,
        FUNC_EGRESS = 3'd2,
        FUNC_REMOVE = 3'd3,
        FUNC_TOUCH  = 3'd4,
        FUNC_SCAN   = 3'd5
    } func_t;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;
    localparam logic [1:0] ST_RETRY  = 2'd3;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_HEADER  = 1'b1;

    localparam int SlotBits = 64 + 32 + 64 + 64 + 1 + 1 + 32;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] seq;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic        has_src;
        logic        pending;
        logic [31:0] sent_time;
    } slot_t;

    // Request as packed on s_tdata: func in the lowest bits, now_time at the top
    typedef struct packed {
        logic [31:0]  now_time;
        logic [15:0]  hdr_len;
        logic         has_src;
        logic [63:0]  src_lo;
        logic [63:0]  src_hi;
        logic [31:0]  seq;
        logic [63:0]  key;
        logic [2:0]   func;
    } req_t;

    // Per-slot verdict of the compare unit
    typedef struct packed {
        logic key_hit;
        logic src_hit;
        logic due;
    } cmp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_MOVE,
        S_WRITE,
        S_EMIT,
        S_WAIT
    } state_t;

endpackage

FILE: design/oat_ram.sv
// Generic single-port-write RAM with registered read.
module oat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and read storage
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

FILE: design/oat_cmp.sv
// Shared compare unit: key match, source id match and timeout test for one slot.
module oat_cmp (
    input  oat_pkg::slot_t slot,
    input  oat_pkg::req_t  req,
    input  logic [15:0]    timeout_limit,
    output oat_pkg::cmp_t  res
);
    import oat_pkg::*;
    logic [31:0] age;

    // Compare the slot against the request
    always_comb
    begin
        age         = req.now_time - slot.sent_time;
        res.key_hit = (slot.key == req.key);
        res.src_hit = slot.pending && slot.has_src &&
                      (slot.src_hi == req.src_hi) && (slot.src_lo == req.src_lo);
        res.due     = slot.pending && (age >= {16'd0, timeout_limit});
    end
endmodule

FILE: design/outstanding_ack_table.sv
// Outstanding acknowledgement table: one slot at a time through a shared compare unit.
// A search passes each slot visited through a read state and a check state, then
// updates and answers through the move (remove only), write and wait states.
// Scan visits every slot; each due slot is held until the next one is found (then sent
// through the emit state) or the table ends, so the final retry result carries tlast.
// One item at a time: s_tready is high only when idle. Reset empties the table and
// restores timeout_limit to 30 and header_limit to 256; slot storage is not cleared.
module outstanding_ack_table #(
    parameter int SLOTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[2:0], contact_key[66:3], seq[98:67], source_id_hi[162:99],
    // source_id_lo[226:163], has_source_id[227], hdr_len[243:228],
    // now_time[275:244], zero fill to 280
    input  logic [279:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], egress_allowed[2], due_key[66:3], due_seq[98:67], zero fill to 104
    output logic [103:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);
    import oat_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [15:0] timeout_reg, header_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] hit_reg, hit_next;
    logic found_reg, found_next;
    logic any_reg, any_next;
    logic [1:0] ost_reg, ost_next;
    logic oeg_reg, oeg_next;
    logic [63:0] okey_reg, okey_next;
    logic [31:0] oseq_reg, oseq_next;
    logic [63:0] hkey_reg, hkey_next;
    logic [31:0] hseq_reg, hseq_next;
    logic olast_reg, olast_next;
    logic ovalid_reg, ovalid_next;

    logic we;
    logic [IW-1:0] waddr, raddr;
    slot_t wdata, rslot;
    logic [SlotBits-1:0] rbits;
    cmp_t cmp;
    logic [IW-1:0] idx_lo;

    assign idx_lo = idx_reg[IW-1:0];
    assign rslot  = slot_t'(rbits);

    oat_ram #(.WIDTH(SlotBits), .DEPTH(1 << IW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rbits)
    );

    oat_cmp u_cmp (
        .slot          (rslot),
        .req           (req_reg),
        .timeout_limit (timeout_reg),
        .res           (cmp)
    );

    // Hold state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            timeout_reg <= 16'd30;
            header_reg  <= 16'd256;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we && cfg_index == CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_HEADER)
            begin
                header_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg <= req_t'(s_tdata[275:0]);
        end
        idx_reg   <= idx_next;
        hit_reg   <= hit_next;
        found_reg <= found_next;
        any_reg   <= any_next;
        ost_reg   <= ost_next;
        oeg_reg   <= oeg_next;
        okey_reg  <= okey_next;
        oseq_reg  <= oseq_next;
        hkey_reg  <= hkey_next;
        hseq_reg  <= hseq_next;
        olast_reg <= olast_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (func_t'(req_reg.func) == FUNC_MARK && req_reg.hdr_len > header_reg)
                    state_next = S_WRITE;
                else if (req_reg.func > FUNC_SCAN)
                    state_next = S_WRITE;
                else if (func_t'(req_reg.func) == FUNC_SCAN && idx_reg >= count_reg)
                    state_next = S_WAIT;
                else if (idx_reg >= count_reg)
                    state_next = (found_reg && func_t'(req_reg.func) == FUNC_REMOVE)
                                 ? S_MOVE : S_WRITE;
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (func_t'(req_reg.func) == FUNC_SCAN && cmp.due)
                    state_next = any_reg ? S_EMIT : S_READ;
                else if (func_t'(req_reg.func) != FUNC_SCAN && cmp.key_hit)
                    state_next = (func_t'(req_reg.func) == FUNC_REMOVE) ? S_MOVE : S_WRITE;
                else
                    state_next = S_READ;
            end
            S_MOVE:    state_next = S_WRITE;
            S_WRITE:   state_next = S_WAIT;
            S_EMIT:    state_next = S_WAIT;
            S_WAIT:
            begin
                if (m_tready)
                    state_next = (func_t'(req_reg.func) == FUNC_SCAN && !olast_reg)
                                 ? S_READ : S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        s_tready    = (state_reg == S_IDLE);
        count_next  = count_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        any_next    = any_reg;
        ost_next    = ost_reg;
        oeg_next    = oeg_reg;
        okey_next   = okey_reg;
        oseq_next   = oseq_reg;
        hkey_next   = hkey_reg;
        hseq_next   = hseq_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg;
        we          = 1'b0;
        waddr       = hit_reg;
        raddr       = idx_lo;
        wdata       = rslot;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                any_next   = 1'b0;
            end
            S_READ:
            begin
                // Read slot idx; result appears next cycle
                raddr = idx_lo;
            end
            S_CHECK:
            begin
                idx_next = idx_reg + 1'b1;
                if (func_t'(req_reg.func) == FUNC_SCAN)
                begin
                    // Hold the new due slot and release the one held before
                    if (cmp.due)
                    begin
                        any_next  = 1'b1;
                        hkey_next = rslot.key;
                        hseq_next = rslot.seq;
                        okey_next = hkey_reg;
                        oseq_next = hseq_reg;
                    end
                end
                else if (cmp.key_hit)
                begin
                    found_next = 1'b1;
                    hit_next   = idx_lo;
                    any_next   = cmp.src_hit;
                    oeg_next   = !rslot.pending;
                    // Remove needs the last slot, every other update the hit slot
                    if (func_t'(req_reg.func) == FUNC_REMOVE)
                        raddr = IW'(count_reg - 1'b1);
                    else
                        raddr = idx_lo;
                end
            end
            S_MOVE:
            begin
                // Last slot is now on the read port; nothing else
                raddr = IW'(count_reg - 1'b1);
            end
            S_WRITE:
            begin
                ovalid_next = 1'b1;
                olast_next  = 1'b1;
                okey_next   = '0;
                oseq_next   = '0;
                ost_next    = ST_DONE;
                oeg_next    = 1'b0;
                case (req_reg.func)
                    FUNC_MARK:
                    begin
                        if (req_reg.hdr_len > header_reg)
                            ost_next = ST_REJECT;
                        else if (!found_reg && count_reg >= CW'(SLOTS))
                            ost_next = ST_REJECT;
                        else
                        begin
                            we = 1'b1;
                            waddr = found_reg ? hit_reg : idx_lo;
                            wdata.key       = req_reg.key;
                            wdata.seq       = req_reg.seq;
                            wdata.has_src   = req_reg.has_src;
                            wdata.src_hi    = req_reg.has_src ? req_reg.src_hi : '0;
                            wdata.src_lo    = req_reg.has_src ? req_reg.src_lo : '0;
                            wdata.pending   = 1'b1;
                            wdata.sent_time = req_reg.now_time;
                            if (!found_reg)
                                count_next = count_reg + 1'b1;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        if (found_reg && any_reg)
                        begin
                            we = 1'b1;
                            wdata.pending = 1'b0;
                        end
                        else
                            ost_next = ST_NONE;
                    end
                    FUNC_EGRESS:
                        oeg_next = found_reg ? oeg_reg : 1'b1;
                    FUNC_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            we = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                        else
                            ost_next = ST_NONE;
                    end
                    FUNC_TOUCH:
                    begin
                        if (found_reg)
                        begin
                            we = 1'b1;
                            wdata.sent_time = req_reg.now_time;
                        end
                        else
                            ost_next = ST_NONE;
                    end
                    FUNC_SCAN:
                        ost_next = ST_NONE;
                    default:
                        ost_next = ST_REJECT;
                endcase
            end
            S_EMIT:
            begin
                ovalid_next = 1'b1;
                ost_next    = ST_RETRY;
                oeg_next    = 1'b0;
                olast_next  = 1'b0;
            end
            S_WAIT:
            begin
                if (m_tready)
                    ovalid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
        // Scan: after the final slot either send the held retry as last or report none
        if (state_reg == S_READ && func_t'(req_reg.func) == FUNC_SCAN && idx_reg >= count_reg)
        begin
            ovalid_next = 1'b1;
            olast_next  = 1'b1;
            ost_next    = any_reg ? ST_RETRY : ST_NONE;
            oeg_next    = 1'b0;
            okey_next   = any_reg ? hkey_reg : '0;
            oseq_next   = any_reg ? hseq_reg : '0;
        end
    end

    assign m_tvalid = ovalid_reg && (state_reg == S_WAIT);
    assign m_tdata  = {5'd0, oseq_reg, okey_reg, oeg_reg, ost_reg};
    assign m_tlast  = olast_reg;
endmodule

FILE: sim/tb_outstanding_ack_table.sv
// Self-checking testbench for the outstanding acknowledgement table.
module tb_outstanding_ack_table;
    import oat_pkg::*;

    localparam int NSLOT = 16;
    localparam int LIMIT_CYCLES = 900000;

    typedef struct packed {
        logic [1:0]  status;
        logic        egress;
        logic [63:0] key;
        logic [31:0] seq;
        logic        last;
    } ack_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [279:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         cfg_we;
    logic         cfg_index;
    logic [15:0]  cfg_data;

    // Table image kept by the testbench
    logic [63:0] tbl_key [NSLOT];
    logic [31:0] tbl_seq [NSLOT];
    logic [63:0] tbl_hi [NSLOT];
    logic [63:0] tbl_lo [NSLOT];
    logic        tbl_has [NSLOT];
    logic        tbl_pend [NSLOT];
    logic [31:0] tbl_time [NSLOT];
    int          tbl_count;
    logic [15:0] cur_timeout;
    logic [15:0] cur_header;

    ack_res_t    pending_results[$];
    int          fail_count;
    int          cycle_count;
    bit          idle_en;
    logic [31:0] clock_now;
    logic [63:0] known_keys [8];

    outstanding_ack_table #(.SLOTS(NSLOT)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic ack_res_t mk_res(logic [1:0] st, logic eg);
        ack_res_t r;
        r = '0;
        r.status = st;
        r.egress = eg;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int lookup_slot(logic [63:0] key);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    // Work out the results of one request and update the table image
    task automatic predict_ack(input req_t rq);
        int s;
        int n;
        int lst;
        ack_res_t r;
        s = lookup_slot(rq.key);
        case (rq.func)
            FUNC_MARK:
            begin
                if (rq.hdr_len > cur_header)
                    pending_results.push_back(mk_res(ST_REJECT, 1'b0));
                else if (s < 0 && tbl_count >= NSLOT)
                    pending_results.push_back(mk_res(ST_REJECT, 1'b0));
                else
                begin
                    if (s < 0)
                    begin
                        s = tbl_count;
                        tbl_count++;
                        tbl_key[s] = rq.key;
                    end
                    tbl_pend[s] = 1'b1;
                    tbl_seq[s] = rq.seq;
                    tbl_has[s] = rq.has_src;
                    tbl_hi[s] = rq.has_src ? rq.src_hi : '0;
                    tbl_lo[s] = rq.has_src ? rq.src_lo : '0;
                    tbl_time[s] = rq.now_time;
                    pending_results.push_back(mk_res(ST_DONE, 1'b0));
                end
            end
            FUNC_CLEAR:
            begin
                if (s >= 0 && tbl_pend[s] && tbl_has[s] && tbl_hi[s] == rq.src_hi
                    && tbl_lo[s] == rq.src_lo)
                begin
                    tbl_pend[s] = 1'b0;
                    pending_results.push_back(mk_res(ST_DONE, 1'b0));
                end
                else
                    pending_results.push_back(mk_res(ST_NONE, 1'b0));
            end
            FUNC_EGRESS:
                pending_results.push_back(mk_res(ST_DONE, s < 0 || !tbl_pend[s]));
            FUNC_REMOVE:
            begin
                if (s < 0)
                    pending_results.push_back(mk_res(ST_NONE, 1'b0));
                else
                begin
                    lst = tbl_count - 1;
                    tbl_key[s] = tbl_key[lst];
                    tbl_seq[s] = tbl_seq[lst];
                    tbl_hi[s] = tbl_hi[lst];
                    tbl_lo[s] = tbl_lo[lst];
                    tbl_has[s] = tbl_has[lst];
                    tbl_pend[s] = tbl_pend[lst];
                    tbl_time[s] = tbl_time[lst];
                    tbl_count--;
                    pending_results.push_back(mk_res(ST_DONE, 1'b0));
                end
            end
            FUNC_TOUCH:
            begin
                if (s < 0)
                    pending_results.push_back(mk_res(ST_NONE, 1'b0));
                else
                begin
                    tbl_time[s] = rq.now_time;
                    pending_results.push_back(mk_res(ST_DONE, 1'b0));
                end
            end
            FUNC_SCAN:
            begin
                n = 0;
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (tbl_pend[i] && 32'(rq.now_time - tbl_time[i]) >= 32'(cur_timeout))
                    begin
                        r = '0;
                        r.status = ST_RETRY;
                        r.key = tbl_key[i];
                        r.seq = tbl_seq[i];
                        pending_results.push_back(r);
                        n++;
                    end
                end
                if (n == 0)
                    pending_results.push_back(mk_res(ST_NONE, 1'b0));
                else
                    pending_results[$].last = 1'b1;
            end
            default:
                pending_results.push_back(mk_res(ST_REJECT, 1'b0));
        endcase
    endtask

    // Send one item, sometimes with a random idle burst beforehand
    task automatic send_item(input req_t rq);
        if (idle_en && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, rq.now_time, rq.hdr_len, rq.has_src, rq.src_lo,
                    rq.src_hi, rq.seq, rq.key, rq.func};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_ack(rq);
    endtask

    function automatic req_t make_req(logic [2:0] f, logic [63:0] key);
        req_t rq;
        rq.func = f;
        rq.key = key;
        rq.seq = $urandom;
        rq.src_hi = {$urandom, $urandom};
        rq.src_lo = {$urandom, $urandom};
        rq.has_src = $urandom_range(0, 3) != 0;
        rq.hdr_len = 16'($urandom_range(0, 255));
        rq.now_time = clock_now;
        return rq;
    endfunction

    // Drop valid, wait until every expected result is in, then let the block settle
    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * NSLOT + 8) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TIMEOUT)
            cur_timeout = val;
        else
            cur_header = val;
        @(posedge clk);
    endtask

    // Directed: every operation, full table, header limit and matching rules
    task automatic test_directed;
        req_t rq;
        rq = make_req(FUNC_EGRESS, 64'h0);
        send_item(rq);
        rq = make_req(FUNC_SCAN, 64'h0);
        send_item(rq);
        rq = make_req(FUNC_MARK, '1);
        rq.hdr_len = 16'd257;
        send_item(rq);
        rq.hdr_len = 16'd256;
        rq.has_src = 1'b1;
        rq.seq = '1;
        rq.src_hi = '1;
        rq.src_lo = '1;
        send_item(rq);
        rq.func = FUNC_CLEAR;
        rq.src_lo = 64'hfffffffffffffffe;
        send_item(rq);
        rq.src_lo = '1;
        send_item(rq);
        rq.func = FUNC_EGRESS;
        send_item(rq);
        rq = make_req(FUNC_MARK, 64'h0);
        rq.has_src = 1'b0;
        rq.src_hi = '0;
        rq.src_lo = '0;
        send_item(rq);
        rq.func = FUNC_CLEAR;
        send_item(rq);
        rq.func = FUNC_TOUCH;
        send_item(rq);
        rq = make_req(FUNC_TOUCH, 64'h1234);
        send_item(rq);
        rq.func = FUNC_REMOVE;
        send_item(rq);
        rq = make_req(3'd6, 64'h0);
        send_item(rq);
        rq = make_req(3'd7, '1);
        send_item(rq);
        // Fill the table past capacity
        for (int i = 0; i < 16; i++)
        begin
            rq = make_req(FUNC_MARK, 64'h100 + i);
            rq.hdr_len = 16'd0;
            send_item(rq);
        end
        rq.now_time = clock_now + 32'd30;
        rq.func = FUNC_SCAN;
        send_item(rq);
        rq = make_req(FUNC_REMOVE, 64'h0);
        send_item(rq);
        drain_results();
    endtask

    // Random: mostly traffic on a few known keys, some unknown keys
    task automatic test_random(input int count);
        req_t rq;
        logic [63:0] key;
        logic [2:0] f;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            if (n > count - 40)
                idle_en = 1'b0;
            clock_now = clock_now + 32'($urandom_range(0, 12));
            if ($urandom_range(0, 20) == 0)
                clock_now = $urandom;
            key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                              : known_keys[$urandom_range(0, 7)];
            pick = $urandom_range(0, 99);
            if (pick < 30)
                f = FUNC_MARK;
            else if (pick < 48)
                f = FUNC_CLEAR;
            else if (pick < 60)
                f = FUNC_EGRESS;
            else if (pick < 70)
                f = FUNC_REMOVE;
            else if (pick < 78)
                f = FUNC_TOUCH;
            else if (pick < 97)
                f = FUNC_SCAN;
            else
                f = 3'($urandom_range(6, 7));
            rq = make_req(f, key);
            // Clears mostly carry the id stored for the key
            if (f == FUNC_CLEAR && lookup_slot(key) >= 0 && $urandom_range(0, 3) != 0)
            begin
                rq.src_hi = tbl_hi[lookup_slot(key)];
                rq.src_lo = tbl_lo[lookup_slot(key)];
            end
            if (f == FUNC_MARK && $urandom_range(0, 9) == 0)
                rq.hdr_len = 16'($urandom);
            send_item(rq);
        end
        drain_results();
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        ack_res_t got;
        ack_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '0;
            got.status = m_tdata[1:0];
            got.egress = m_tdata[2];
            got.key = m_tdata[66:3];
            got.seq = m_tdata[98:67];
            got.last = m_tlast;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.egress !== want.egress
                    || got.key !== want.key || got.seq !== want.seq
                    || got.last !== want.last)
                begin
                    $display("%0t: expected st=%0d eg=%0d key=%h seq=%h last=%0d, got st=%0d eg=%0d key=%h seq=%h last=%0d",
                             $realtime, want.status, want.egress, want.key, want.seq,
                             want.last, got.status, got.egress, got.key, got.seq,
                             got.last);
                    fail_count++;
                end
            end
        end
    end

    // Random stall on the result side
    always @(posedge clk)
    begin
        if (!idle_en)
            m_tready <= 1'b1;
        else if ($urandom_range(0, 3) == 0)
            m_tready <= ~m_tready;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_outstanding_ack_table: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b1;
        cfg_we = 1'b0;
        cfg_index = CFG_TIMEOUT;
        cfg_data = '0;
        fail_count = 0;
        cycle_count = 0;
        idle_en = 1'b1;
        tbl_count = 0;
        cur_timeout = 16'd30;
        cur_header = 16'd256;
        clock_now = 32'hffffff00;
        for (int i = 0; i < 8; i++)
            known_keys[i] = (i == 0) ? 64'h0 : (i == 1) ? '1 : {$urandom, $urandom};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_cfg(CFG_TIMEOUT, 16'd0);
        write_cfg(CFG_HEADER, 16'hffff);
        test_random(80);
        write_cfg(CFG_TIMEOUT, 16'hffff);
        write_cfg(CFG_HEADER, 16'd0);
        test_random(50);
        idle_en = 1'b1;
        write_cfg(CFG_TIMEOUT, 16'd20);
        write_cfg(CFG_HEADER, 16'd200);
        test_random(120);

        if (fail_count == 0)
            $display("tb_outstanding_ack_table: PASS");
        else
            $display("tb_outstanding_ack_table: FAIL");
        $finish;
    end

endmodule
